[hw/rtl/bdcs_pkg.sv]
// Package for the data channel selector: constants, codes, types and bit permutation helpers.
`default_nettype none

package bdcs_pkg;

	// Channel space and field widths
	localparam int NUM_CHAN   = 37;
	localparam int CHAN_W     = 6;
	localparam int ORD_W      = 64;
	localparam int BITS_W     = 7;
	localparam int HOP_W      = 5;
	localparam int AA_W       = 32;
	localparam int MODE_W     = 2;
	localparam int PRN_W      = 16;
	localparam int PROD_W     = CHAN_W + HOP_W;
	localparam int SCALE_W    = CHAN_W + PRN_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CSA2_ROUNDS = 3;

	// Mod-37 unit: one 16-bit digit a cycle, reciprocal multiplication
	localparam int DIGIT_W    = PRN_W;
	localparam int ORD_DIGITS = ORD_W / DIGIT_W;
	localparam int DIGIT_MOD  = (1 << DIGIT_W) % NUM_CHAN;    // 2^16 mod 37
	localparam int RED_W      = DIGIT_W + 1;
	localparam int RECIP_SH   = RED_W + CHAN_W;
	localparam int RECIP_W    = RED_W + 1;
	localparam int RECIP      = ((1 << RECIP_SH) + NUM_CHAN - 1) / NUM_CHAN;

	localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(NUM_CHAN - 1);
	localparam logic [HOP_W-1:0]  HOP_MIN   = HOP_W'(5);
	localparam logic [HOP_W-1:0]  HOP_MAX   = HOP_W'(16);
	localparam logic [HOP_W-1:0]  HOP_RESET = HOP_W'(5);

	// Mode codes
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CSA1 = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CSA2 = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AA   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd3;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MODE = 2'd1,
		ST_HOP  = 2'd2,
		ST_FEW  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_COUNT,
		S_MOD,
		S_STEP,
		S_REM,
		S_ROUND,
		S_PRN,
		S_SCALE,
		S_NTH,
		S_DONE
	} state_t;

	// Live configuration handed to the sequencer
	typedef struct packed {
		logic [NUM_CHAN-1:0] chan_map;
		logic [HOP_W-1:0]    hop;
		logic [AA_W-1:0]     aa;
		logic [MODE_W-1:0]   mode;
	} cfg_t;

	// One finished result
	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		status_t           st;
	} res_t;

	// Remainder modulo the channel count; quotient by reciprocal multiplication
	function automatic logic [CHAN_W-1:0] mod_chan(input logic [RED_W-1:0] n);
		logic [RED_W+RECIP_W-1:0] t;
		logic [RED_W-1:0]         q;
		logic [RED_W-1:0]         r;
		begin
			t = (RED_W+RECIP_W)'(n) * (RED_W+RECIP_W)'(RECIP);
			q = RED_W'(t[RED_W+RECIP_W-1:RECIP_SH]);
			r = n - q * RED_W'(NUM_CHAN);
			return r[CHAN_W-1:0];
		end
	endfunction

	// Reverse the bit order within one byte
	function automatic logic [7:0] flip8(input logic [7:0] v);
		logic [7:0] o;
		begin
			for (int i = 0; i < 8; i++)
				o[i] = v[7-i];
			return o;
		end
	endfunction

	// One CSA#2 round: byte-wise bit reversal, then times 17 plus the identifier
	function automatic logic [PRN_W-1:0] csa2_round(input logic [PRN_W-1:0] prn,
			input logic [PRN_W-1:0] id);
		logic [PRN_W-1:0] p;
		begin
			p = {flip8(prn[15:8]), flip8(prn[7:0])};
			return {p[PRN_W-5:0], 4'b0000} + p + id;
		end
	endfunction

endpackage

`default_nettype wire

[hw/rtl/bdcs_seq.sv]
// Sequencer for one channel selection: map scans, mod-37 unit and CSA#2 rounds.
`default_nettype none

module bdcs_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire bdcs_pkg::cfg_t              cfg,
	input  wire logic [bdcs_pkg::ORD_W-1:0]  ordinal,
	output logic                             idle,
	output logic                             res_valid,
	output bdcs_pkg::res_t                   res,
	input  wire logic                        res_take
);
	import bdcs_pkg::*;

	state_t              state_q, state_d;
	logic [ORD_W-1:0]    sreg_q, sreg_d;
	logic [BITS_W-1:0]   bits_q, bits_d;
	logic [CHAN_W-1:0]   r_q, r_d;
	logic                tag_un_q, tag_un_d;
	logic [CHAN_W-1:0]   idx_q, idx_d;
	logic [CHAN_W-1:0]   cnt_q, cnt_d;
	logic [CHAN_W-1:0]   seen_q, seen_d;
	logic [CHAN_W-1:0]   k_q, k_d;
	logic [PRN_W-1:0]    prn_q, prn_d;
	logic [1:0]          rnd_q, rnd_d;
	res_t                res_q, res_d;

	logic [PRN_W-1:0]    id;
	logic [CHAN_W-1:0]   step;
	logic [PROD_W-1:0]   prod;
	logic [SCALE_W-1:0]  scaled;

	// Channel identifier and the two small products
	assign id     = cfg.aa[31:16] ^ cfg.aa[15:0];
	assign step   = (r_q == LAST_CHAN) ? '0 : r_q + CHAN_W'(1);
	assign prod   = PROD_W'(step) * PROD_W'(cfg.hop);
	assign scaled = SCALE_W'(cnt_q) * SCALE_W'(prn_q);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		sreg_q   <= sreg_d;
		bits_q   <= bits_d;
		r_q      <= r_d;
		tag_un_q <= tag_un_d;
		idx_q    <= idx_d;
		cnt_q    <= cnt_d;
		seen_q   <= seen_d;
		k_q      <= k_d;
		prn_q    <= prn_d;
		rnd_q    <= rnd_d;
		res_q    <= res_d;
	end

	// Next state and datapath control
	always_comb begin
		state_d  = state_q;
		sreg_d   = sreg_q;
		bits_d   = bits_q;
		r_d      = r_q;
		tag_un_d = tag_un_q;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		seen_d   = seen_q;
		k_d      = k_q;
		prn_d    = prn_q;
		rnd_d    = rnd_q;
		res_d    = res_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					sreg_d = ordinal;
					idx_d  = '0;
					cnt_d  = '0;
					if (cfg.mode != MODE_CSA1 && cfg.mode != MODE_CSA2) begin
						res_d   = '{chan: '0, st: ST_MODE};
						state_d = S_DONE;
					end else if (cfg.mode == MODE_CSA1 &&
							!(cfg.hop inside {[HOP_MIN:HOP_MAX]})) begin
						res_d   = '{chan: '0, st: ST_HOP};
						state_d = S_DONE;
					end else begin
						state_d = S_COUNT;
					end
				end
			end
			// count used channels, one map bit a cycle
			S_COUNT: begin
				cnt_d = cnt_q + CHAN_W'(cfg.chan_map[idx_q]);
				idx_d = idx_q + CHAN_W'(1);
				if (idx_q == LAST_CHAN) begin
					if (cnt_d < CHAN_W'(2)) begin
						res_d   = '{chan: '0, st: ST_FEW};
						state_d = S_DONE;
					end else if (cfg.mode == MODE_CSA1) begin
						bits_d   = BITS_W'(ORD_DIGITS);
						r_d      = '0;
						tag_un_d = 1'b0;
						state_d  = S_MOD;
					end else begin
						prn_d   = sreg_q[PRN_W-1:0] ^ id;
						rnd_d   = '0;
						state_d = S_ROUND;
					end
				end
			end
			// mod 37, one 16-bit digit a cycle, MSB first
			S_MOD: begin
				r_d    = mod_chan(RED_W'(r_q) * RED_W'(DIGIT_MOD) +
					RED_W'(sreg_q[ORD_W-1 -: DIGIT_W]));
				sreg_d = {sreg_q[ORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
				bits_d = bits_q - BITS_W'(1);
				if (bits_q == BITS_W'(1)) begin
					if (!tag_un_q) begin
						state_d = S_STEP;
					end else if (cfg.chan_map[r_d]) begin
						res_d   = '{chan: r_d, st: ST_OK};
						state_d = S_DONE;
					end else if (cfg.mode == MODE_CSA1) begin
						k_d     = r_d;
						state_d = S_REM;
					end else begin
						state_d = S_SCALE;
					end
				end
			end
			// step times hop, then reduce again
			S_STEP: begin
				sreg_d   = {DIGIT_W'(prod), {(ORD_W-DIGIT_W){1'b0}}};
				bits_d   = BITS_W'(1);
				r_d      = '0;
				tag_un_d = 1'b1;
				state_d  = S_MOD;
			end
			// unmapped mod used count by repeated subtraction
			S_REM: begin
				if (k_q >= cnt_q) begin
					k_d = k_q - cnt_q;
				end else begin
					idx_d   = '0;
					seen_d  = '0;
					state_d = S_NTH;
				end
			end
			S_ROUND: begin
				prn_d = csa2_round(prn_q, id);
				rnd_d = rnd_q + 2'd1;
				if (rnd_q == 2'(CSA2_ROUNDS - 1))
					state_d = S_PRN;
			end
			S_PRN: begin
				prn_d    = prn_q ^ id;
				sreg_d   = {prn_q ^ id, {(ORD_W-PRN_W){1'b0}}};
				bits_d   = BITS_W'(1);
				r_d      = '0;
				tag_un_d = 1'b1;
				state_d  = S_MOD;
			end
			// remap index = used count * prn >> 16
			S_SCALE: begin
				k_d     = scaled[SCALE_W-1:PRN_W];
				idx_d   = '0;
				seen_d  = '0;
				state_d = S_NTH;
			end
			// find the k-th used channel
			S_NTH: begin
				idx_d = idx_q + CHAN_W'(1);
				if (cfg.chan_map[idx_q]) begin
					seen_d = seen_q + CHAN_W'(1);
					if (seen_q == k_q) begin
						res_d   = '{chan: idx_q, st: ST_OK};
						state_d = S_DONE;
					end
				end
				if (idx_q == LAST_CHAN && state_d != S_DONE) begin
					res_d   = '{chan: '0, st: ST_OK};
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_take)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

`default_nettype wire

[hw/rtl/ble_data_channel_select.sv]
// Top level of the BLE data channel selector: config registers, sequencer and output register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, conn_event            | item in, block drives in_stall
//  output  | out_valid, out_stall, chan_sel, status    | item out, sink drives out_stall
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes, always ready
//
// One item at a time. The time from one accept to the next is set by the scans of the
// channel map (count and remap search), the remap subtraction loop and the mod-37 unit,
// which takes 16 ordinal bits a cycle, and grows while the output stalls. A bad mode or hop
// skips all of these; too few channels skips all but the count scan.
// After reset the map is all ones, hop 5, access address 0, mode unresolved.
// A finished item waits in the output register; a new item is taken meanwhile,
// and the sequencer holds its result only when that register is full and stalled.
`default_nettype none

module ble_data_channel_select (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [bdcs_pkg::ORD_W-1:0]       conn_event,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [bdcs_pkg::CHAN_W-1:0]           chan_sel,
	output logic [1:0]                            status,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [bdcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bdcs_pkg::NUM_CHAN-1:0]    cfg_data
);
	import bdcs_pkg::*;

	cfg_t  cfg_q;
	logic  seq_idle;
	logic  seq_valid;
	res_t  seq_res;
	logic  take;
	logic  out_valid_q;
	res_t  out_res_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chan_map <= '1;
			cfg_q.hop      <= HOP_RESET;
			cfg_q.aa       <= '0;
			cfg_q.mode     <= MODE_NONE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAP:  cfg_q.chan_map <= cfg_data;
				REG_HOP:  cfg_q.hop      <= cfg_data[HOP_W-1:0];
				REG_AA:   cfg_q.aa       <= cfg_data[AA_W-1:0];
				REG_MODE: cfg_q.mode     <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = !seq_idle;

	bdcs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && !in_stall),
		.cfg       (cfg_q),
		.ordinal   (conn_event),
		.idle      (seq_idle),
		.res_valid (seq_valid),
		.res       (seq_res),
		.res_take  (take)
	);

	// Output register
	assign take = seq_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			out_res_q <= seq_res;
	end

	assign out_valid = out_valid_q;
	assign chan_sel  = out_res_q.chan;
	assign status    = out_res_q.st;

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the BLE data channel selector (CSA#1 and CSA#2).
`timescale 1ns / 1ps

module testbench;
	import bdcs_pkg::*;

	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;    // undefined mode code
	localparam int RAND_ITEMS  = 1250;
	localparam int DRAIN_TICKS = 200;                   // beyond the slowest item
	localparam int MAX_PRINTS  = 100;

	// One expected result, with the ordinal that caused it
	typedef struct {
		logic [ORD_W-1:0] ordinal;
		res_t             res;
	} expected_t;

	// Scoreboard: register shadow, channel predictor and queue of expected items
	class channel_scoreboard;
		logic [NUM_CHAN-1:0] chan_map;
		logic [HOP_W-1:0]    hop;
		logic [AA_W-1:0]     aa;
		logic [MODE_W-1:0]   mode;
		expected_t           expected_channels[$];
		int unsigned         faults;

		function new();
			chan_map = {NUM_CHAN{1'b1}};
			hop      = HOP_RESET;
			aa       = '0;
			mode     = MODE_NONE;
			faults   = 0;
		endfunction

		// Bits above a register's width are dropped
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [NUM_CHAN-1:0] word);
			case (idx)
				REG_MAP:  chan_map = word;
				REG_HOP:  hop      = word[HOP_W-1:0];
				REG_AA:   aa       = word[AA_W-1:0];
				REG_MODE: mode     = word[MODE_W-1:0];
			endcase
		endfunction

		// Channel and status for one event under the current registers
		function res_t select_channel(logic [ORD_W-1:0] ordinal);
			res_t             r;
			int unsigned      used, unmapped, slot, seen, id, prn;
			logic [PRN_W-1:0] p;
			r.chan = '0;
			r.st   = ST_OK;
			used   = $countones(chan_map);
			// mode first, then hop (CSA#1 only), then channel count
			if (mode != MODE_CSA1 && mode != MODE_CSA2)
				r.st = ST_MODE;
			else if (mode == MODE_CSA1 && (hop < HOP_MIN || hop > HOP_MAX))
				r.st = ST_HOP;
			else if (used < 2)
				r.st = ST_FEW;
			else begin
				if (mode == MODE_CSA1) begin
					unmapped = ((int'(ordinal % NUM_CHAN) + 1) % NUM_CHAN) * hop % NUM_CHAN;
					slot     = unmapped % used;
				end else begin
					id  = aa[31:16] ^ aa[15:0];
					prn = ordinal[15:0] ^ id;
					// per round: bit-reverse each byte, then times 17 plus id
					repeat (CSA2_ROUNDS) begin
						for (int b = 0; b < 8; b++) begin
							p[b]     = prn[7-b];
							p[b + 8] = prn[15-b];
						end
						prn = (17 * p + id) & 32'hFFFF;
					end
					prn      = prn ^ id;
					unmapped = prn % NUM_CHAN;
					slot     = (used * prn) >> 16;
				end
				// unused channel: take the slot-th used one in ascending order
				if (chan_map[unmapped])
					r.chan = CHAN_W'(unmapped);
				else begin
					seen = 0;
					for (int ch = 0; ch < NUM_CHAN; ch++)
						if (chan_map[ch]) begin
							if (seen == slot)
								r.chan = CHAN_W'(ch);
							seen++;
						end
				end
			end
			return r;
		endfunction

		function void note_item(logic [ORD_W-1:0] ordinal);
			expected_t e;
			e.ordinal = ordinal;
			e.res     = select_channel(ordinal);
			expected_channels.push_back(e);
		endfunction

		// Prints one line per mismatch (up to a cap) and counts every one
		task report_mismatch(string what);
			if (faults < MAX_PRINTS)
				$display("%0t ns  mismatch: %s", $time, what);
			faults++;
		endtask

		task check_item(logic [CHAN_W-1:0] chan, logic [1:0] st);
			expected_t e;
			if (expected_channels.size() == 0) begin
				report_mismatch($sformatf("unexpected item: channel %0d status %0d", chan, st));
				return;
			end
			e = expected_channels.pop_front();
			if (chan !== e.res.chan)
				report_mismatch($sformatf("ordinal %h: channel %0d, want %0d",
					e.ordinal, chan, e.res.chan));
			if (st !== e.res.st)
				report_mismatch($sformatf("ordinal %h: status %0d, want %s",
					e.ordinal, st, e.res.st.name()));
		endtask

		task check_leftover();
			while (expected_channels.size() != 0)
				report_mismatch($sformatf("ordinal %h: no result came",
					expected_channels.pop_front().ordinal));
		endtask
	endclass

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_stall;
	logic [ORD_W-1:0]     conn_event    = '0;
	logic                 out_valid;
	logic                 out_stall     = 1'b0;
	logic [CHAN_W-1:0]    chan_sel;
	logic [1:0]           status;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [NUM_CHAN-1:0]  cfg_data      = '0;

	channel_scoreboard board = new();
	bit                calm  = 1'b0;    // no idling on either side
	int                hold_left = 0;

	ble_data_channel_select dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.conn_event   (conn_event),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.chan_sel     (chan_sel),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Receiver stall: short random stalls plus rare long holds
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (calm)
			out_stall <= 1'b0;
		else if ($urandom_range(9999) < 2) begin
			out_stall <= 1'b1;
			hold_left <= $urandom_range(200, 20);
		end else
			out_stall <= ($urandom_range(99) < 18);
	end

	// Result checker
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			board.check_item(chan_sel, status);

	// Register write; cfg_valid stays high for a following write in the same burst
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NUM_CHAN-1:0] value);
		logic [NUM_CHAN-1:0] word;
		// bits above the register width carry noise
		word = {5'($urandom), 32'($urandom)};
		case (idx)
			REG_MAP:  word = value;
			REG_HOP:  word[HOP_W-1:0]  = value[HOP_W-1:0];
			REG_AA:   word[AA_W-1:0]   = value[AA_W-1:0];
			REG_MODE: word[MODE_W-1:0] = value[MODE_W-1:0];
		endcase
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, word);
	endtask

	// Present one item and hold it until taken
	task automatic send_item(input logic [ORD_W-1:0] ordinal);
		cfg_valid <= 1'b0;    // any write burst is over once items flow
		if (!calm)
			while ($urandom_range(99) < 18) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid   <= 1'b1;
		conn_event <= ordinal;
		do @(posedge clk); while (in_stall);
		board.note_item(ordinal);
	endtask

	// Stop sending and wait for every expected item
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.expected_channels.size() != 0)
			@(posedge clk);
	endtask

	int unsigned         rand_items = 0;
	int unsigned         phase_no   = 0;
	int unsigned         n_items, pick;
	logic [ORD_W-1:0]    base, ordinal;
	logic [NUM_CHAN-1:0] map_word;

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset registers: mode unresolved
		send_item('0);
		send_item({ORD_W{1'b1}});
		wait_drained();
		// Spare mode code behaves as unresolved
		set_reg(REG_MODE, MODE_SPARE);
		send_item(64'd5);
		wait_drained();
		// Hop just outside the legal range, and at the field extremes
		set_reg(REG_MODE, MODE_CSA1);
		set_reg(REG_HOP, 4);
		send_item(64'd12);
		wait_drained();
		set_reg(REG_HOP, 17);
		send_item(64'd1);
		wait_drained();
		// bad hop wins over an empty map
		set_reg(REG_HOP, 0);
		set_reg(REG_MAP, '0);
		send_item(64'd2);
		wait_drained();
		set_reg(REG_HOP, 31);
		send_item(64'd3);
		wait_drained();
		// CSA#1, smallest hop, every channel used; ordinal wrap points
		set_reg(REG_HOP, 5);
		set_reg(REG_MAP, {NUM_CHAN{1'b1}});
		send_item(64'd0);
		send_item(64'd36);
		send_item(64'd37);
		send_item({ORD_W{1'b1}});
		wait_drained();
		// Largest hop, only two channels: remap path
		set_reg(REG_HOP, 16);
		set_reg(REG_MAP, 37'h10_0000_0001);
		send_item(64'd1);
		send_item(64'd1000);
		wait_drained();
		// Fewer than two used channels
		set_reg(REG_MAP, 37'h10_0000_0000);
		send_item(64'd7);
		wait_drained();
		set_reg(REG_MAP, '0);
		send_item(64'd8);
		wait_drained();
		// CSA#2 with a typical access address
		set_reg(REG_MODE, MODE_CSA2);
		set_reg(REG_AA, 32'h8E89_BED6);
		set_reg(REG_MAP, {NUM_CHAN{1'b1}});
		send_item(64'd0);
		send_item(64'd1);
		send_item(64'd3);
		wait_drained();
		set_reg(REG_MAP, 37'h1F_0000_00F0);
		send_item(64'hFFFF);
		send_item(64'hA5A5_0000_FFFF_1234);
		wait_drained();
		// CSA#2 ignores the hop; then back to unresolved
		set_reg(REG_HOP, 0);
		set_reg(REG_AA, 32'hFFFF_FFFF);
		set_reg(REG_MAP, 37'h1000);
		send_item(64'd9);
		wait_drained();
		set_reg(REG_MODE, MODE_NONE);
		send_item(64'd10);
		wait_drained();

		// Random phases: new registers, then a run of mostly consecutive events
		while (rand_items < RAND_ITEMS) begin
			phase_no++;
			calm = (phase_no >= 6 && phase_no <= 9);
			if (phase_no == 1 || $urandom_range(99) < 70) begin
				pick = $urandom_range(99);
				set_reg(REG_MODE, pick < 45 ? MODE_CSA1 : pick < 92 ? MODE_CSA2 :
					pick < 96 ? MODE_NONE : MODE_SPARE);
			end
			if (phase_no == 1 || $urandom_range(99) < 60)
				set_reg(REG_HOP, $urandom_range(99) < 85 ? $urandom_range(16, 5) :
					$urandom_range(31));
			if (phase_no == 1 || $urandom_range(99) < 60)
				case ($urandom_range(9))
					0:       set_reg(REG_AA, '0);
					1:       set_reg(REG_AA, 32'hFFFF_FFFF);
					default: set_reg(REG_AA, $urandom);
				endcase
			if (phase_no == 1 || $urandom_range(99) < 70) begin
				case ($urandom_range(9))
					0: map_word = {NUM_CHAN{1'b1}};
					1, 2, 3: map_word = {5'($urandom), 32'($urandom)};
					4, 5, 6: begin
						map_word = '0;
						repeat ($urandom_range(6, 2)) map_word[$urandom_range(36)] = 1'b1;
					end
					7, 8: begin
						map_word = {NUM_CHAN{1'b1}};
						repeat ($urandom_range(4, 1)) map_word[$urandom_range(36)] = 1'b0;
					end
					default: begin
						map_word = '0;
						if ($urandom_range(1))
							map_word[$urandom_range(36)] = 1'b1;
					end
				endcase
				set_reg(REG_MAP, map_word);
			end

			n_items = $urandom_range(110, 40);
			base    = {$urandom, $urandom};
			if ($urandom_range(3) == 0)
				base[15:0] = 16'hFFF0;    // counter wraps inside the run
			for (int i = 0; i < n_items; i++) begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: ordinal = base + i;
					6:       ordinal = {$urandom, $urandom};
					7:       ordinal = $urandom_range(300);
					8:       ordinal = 64'd37 * $urandom + $urandom_range(2);
					default: ordinal = {ORD_W{1'b1}} - $urandom_range(100);
				endcase
				send_item(ordinal);
				rand_items++;
			end
			wait_drained();
		end
		calm = 1'b0;

		repeat (DRAIN_TICKS) @(posedge clk);
		board.check_leftover();
		if (board.faults == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog
	initial begin
		#6_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/bdcs_pkg.sv
hw/rtl/bdcs_seq.sv
hw/rtl/ble_data_channel_select.sv
bench/testbench.sv
